// ===== design/mkts_pkg.sv =====
`timescale 1ns / 1ps

package mkts_pkg;

    // Depth of the tie chain, the count width that follows from it, and field widths.
    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = 7;
    localparam int CODE_W      = 10;
    localparam int VAL_W       = 16;

    // One incoming record.
    typedef struct packed {
        logic [CODE_W-1:0] record_code;
        logic [VAL_W-1:0]  weight;
        logic [VAL_W-1:0]  height;
        logic              last_record;
    } rec_req_t;

    // One emitted tied record.
    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic [VAL_W-1:0]  out_weight;
        logic [VAL_W-1:0]  out_height;
        logic [CNT_W-1:0]  tie_count;
        logic              last_result;
    } res_req_t;

    // Contents of one chain cell.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [VAL_W-1:0]  height;
    } cell_data_t;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic       shift;
        cell_data_t data;
    } cell_link_t;

    // Command broadcast to every cell.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_OUT
    } cell_op_t;

endpackage

// ===== design/max_key_ties_sorted_by_second_key.sv =====
`timescale 1ns / 1ps

// Keeps every record tied at the largest weight of a set, sorted by height.
// Records arrive on the rec channel, one request per record; rec_valid and
// rec_stall form the handshake, and a record is taken on an edge with
// rec_valid high and rec_stall low. While collecting, one record is taken
// every cycle: a chain of MAX_RECORDS cells places it in its sorted slot in
// that single cycle, with all larger heights shifting one cell right.
// A record with last_record set is placed like the others, and then the block
// turns to emitting: from the next cycle on, res_valid is high and cell zero
// of the chain drives the res request. Each accepted result shifts the whole
// chain one cell left, so results leave at one per cycle while res_stall is low,
// in ascending height, with tie_count on every result and last_result on the
// final one. rec is stalled while the set is emitted. A stalled result simply
// holds in cell zero. Reset clears the weight maximum, the fill count and the
// state machine; the cell contents are not cleared and are never read beyond
// the fill count. A tied record arriving with MAX_RECORDS entries held is
// dropped.
module max_key_ties_sorted_by_second_key
    import mkts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rec_valid,
    output logic     rec_stall,
    input  rec_req_t rec,
    output logic     res_valid,
    input  logic     res_stall,
    output res_req_t res
);

    typedef enum logic {
        S_COLLECT,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [VAL_W-1:0] max_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;

    logic             rec_acc;
    logic             res_acc;
    logic             do_clear;
    logic             do_tie;
    logic             is_last_out;
    cell_op_t         op;
    cell_data_t       new_data;

    logic [MAX_RECORDS-1:0] occ;
    cell_link_t             links [MAX_RECORDS];

    // Handshakes.
    assign rec_stall = (state_reg == S_EMIT);
    assign res_valid = (state_reg == S_EMIT);
    assign rec_acc   = rec_valid && !rec_stall;
    assign res_acc   = res_valid && !res_stall;

    // A heavier record, or the first of a set, restarts the store.
    assign do_clear = (count_reg == '0) || (rec.weight > max_reg);
    assign do_tie   = !do_clear && (rec.weight == max_reg)
                      && (count_reg < CNT_W'(MAX_RECORDS));

    assign new_data.code   = rec.record_code;
    assign new_data.height = rec.height;

    // Command for the chain.
    always_comb
    begin
        if (rec_acc && (do_clear || do_tie))
        begin
            op = CELL_INSERT;
        end
        else if (res_acc)
        begin
            op = CELL_SHIFT_OUT;
        end
        else
        begin
            op = CELL_HOLD;
        end
    end

    // The chain of cells; occupancy follows the fill count and is masked on a restart.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++)
        begin : g_cell
            assign occ[gi] = !do_clear && (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                cell_link_t head_link;
                assign head_link.shift = 1'b0;
                assign head_link.data  = new_data;

                mkts_cell u_cell (
                    .clk        (clk),
                    .op         (op),
                    .occ        (occ[gi]),
                    .left_occ   (1'b1),
                    .left       (head_link),
                    .new_data   (new_data),
                    .right_data (links[(gi + 1) % MAX_RECORDS].data),
                    .link       (links[gi])
                );
            end
            else
            begin : g_body
                mkts_cell u_cell (
                    .clk        (clk),
                    .op         (op),
                    .occ        (occ[gi]),
                    .left_occ   (occ[gi-1]),
                    .left       (links[gi-1]),
                    .new_data   (new_data),
                    .right_data (links[(gi + 1) % MAX_RECORDS].data),
                    .link       (links[gi])
                );
            end
        end
    endgenerate

    // The result's code and height come straight from the head of the chain.
    assign is_last_out     = ((idx_reg + CNT_W'(1)) == count_reg);
    assign res.out_code    = links[0].data.code;
    assign res.out_height  = links[0].data.height;
    assign res.out_weight  = max_reg;
    assign res.tie_count   = count_reg;
    assign res.last_result = is_last_out;

    // Sequencer: collect records, then emit the tied set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            max_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_COLLECT:
                begin
                    if (rec_acc)
                    begin
                        if (do_clear)
                        begin
                            max_reg   <= rec.weight;
                            count_reg <= CNT_W'(1);
                        end
                        else if (do_tie)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        idx_reg <= '0;
                        if (rec.last_record)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (res_acc)
                    begin
                        if (is_last_out)
                        begin
                            state_reg <= S_COLLECT;
                            max_reg   <= '0;
                            count_reg <= '0;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    // The fill count never exceeds the chain length.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("tie count beyond chain length");

    // While emitting there is always a record left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (count_reg != '0) && (idx_reg < count_reg))
        else $error("emitting with no record left");

    // A last record starts emission on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_acc && rec.last_record) |=> res_valid)
        else $error("last record did not start emission");

    // The final result returns the block to collecting with an empty store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_acc && res.last_result) |=> !res_valid && (count_reg == '0))
        else $error("store not emptied after final result");

endmodule

// ===== design/mkts_cell.sv =====
`timescale 1ns / 1ps

module mkts_cell
    import mkts_pkg::*;
(
    input  logic       clk,
    input  cell_op_t   op,
    input  logic       occ,
    input  logic       left_occ,
    input  cell_link_t left,
    input  cell_data_t new_data,
    input  cell_data_t right_data,
    output cell_link_t link
);

    cell_data_t data_reg;
    cell_data_t data_next;
    logic       shift;

    // An occupied cell whose height exceeds the newcomer moves one place right.
    assign shift = occ && (data_reg.height > new_data.height);

    assign link.shift = shift;
    assign link.data  = data_reg;

    // Pick the next contents: hold, take the newcomer, take the left or right neighbor.
    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                if (shift || !occ)
                begin
                    if (left.shift)
                    begin
                        data_next = left.data;
                    end
                    else if (shift || left_occ)
                    begin
                        data_next = new_data;
                    end
                end
            end
            CELL_SHIFT_OUT:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // The record store itself needs no reset; the fill count says what is valid.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mkts_pkg::*;

    localparam int IDLE_PCT    = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int LIMIT       = 200000;
    localparam int RAND_ITEMS  = 148;
    localparam int FULL_LEN    = 70;
    localparam int N_DIR       = 22;

    // One row of the directed table. A solo row is a set of one record, so
    // its only result is the record itself with a tie count of one.
    typedef struct {
        rec_req_t req;
        bit       solo;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     rec_valid;
    logic     rec_stall;
    rec_req_t rec;
    logic     res_valid;
    logic     res_stall;
    res_req_t res;

    // Predicted tie store of the current set.
    logic [VAL_W-1:0]  tie_w;
    int                tie_n;
    logic [CODE_W-1:0] tie_code [MAX_RECORDS];
    logic [VAL_W-1:0]  tie_height [MAX_RECORDS];
    res_req_t          results_due [$];

    bit quiet;
    bit hold_go;
    int n_items;
    int n_sets;
    int n_results;
    int n_errors;
    int most_ties;
    int cycles = 0;

    dir_row_t dir_rows [N_DIR];

    max_key_ties_sorted_by_second_key uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rec_req_t rec_of(input logic [CODE_W-1:0] code,
                                        input logic [VAL_W-1:0] w,
                                        input logic [VAL_W-1:0] h,
                                        input logic last);
        rec_req_t r;
        r.record_code = code;
        r.weight      = w;
        r.height      = h;
        r.last_record = last;
        return r;
    endfunction

    // Insert a tied record after every entry of equal or smaller height.
    function automatic void place_tie(input rec_req_t r);
        int pos;
        if (tie_n >= MAX_RECORDS)
            return;
        pos = tie_n;
        for (int k = 0; k < tie_n; k++)
        begin
            if (tie_height[k] > r.height)
            begin
                pos = k;
                break;
            end
        end
        for (int k = tie_n; k > pos; k--)
        begin
            tie_code[k]   = tie_code[k-1];
            tie_height[k] = tie_height[k-1];
        end
        tie_code[pos]   = r.record_code;
        tie_height[pos] = r.height;
        tie_n++;
    endfunction

    // Track the maximum weight and its ties; a last record releases the set.
    function automatic void weigh_record(input rec_req_t r, input bit solo);
        res_req_t o;
        if (tie_n == 0 || r.weight > tie_w)
        begin
            tie_w = r.weight;
            tie_n = 0;
            place_tie(r);
        end
        else if (r.weight == tie_w)
        begin
            place_tie(r);
        end
        if (!r.last_record)
            return;
        n_sets++;
        if (tie_n > most_ties)
            most_ties = tie_n;
        if (solo)
        begin
            o.out_code    = r.record_code;
            o.out_weight  = r.weight;
            o.out_height  = r.height;
            o.tie_count   = 7'd1;
            o.last_result = 1'b1;
            results_due.push_back(o);
        end
        else
        begin
            for (int k = 0; k < tie_n; k++)
            begin
                o.out_code    = tie_code[k];
                o.out_weight  = tie_w;
                o.out_height  = tie_height[k];
                o.tie_count   = CNT_W'(tie_n);
                o.last_result = (k == tie_n - 1);
                results_due.push_back(o);
            end
        end
        tie_w = '0;
        tie_n = 0;
    endfunction

    // Offer one request, idling now and then, and predict once it is taken.
    task automatic offer_record(input rec_req_t r, input bit solo);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            rec_valid <= 1'b0;
            @(posedge clk);
        end
        rec_valid <= 1'b1;
        rec       <= r;
        @(posedge clk);
        while (rec_stall)
            @(posedge clk);
        n_items++;
        weigh_record(r, solo);
    endtask

    // One set of records; narrow sets draw from small pools to force ties.
    task automatic send_set(input int len, input bit wide, input logic [VAL_W-1:0] w_base);
        rec_req_t r;
        for (int i = 0; i < len; i++)
        begin
            r.record_code = wide ? CODE_W'($urandom) : CODE_W'($urandom_range(100, 999));
            r.weight      = wide ? VAL_W'($urandom) : w_base + VAL_W'($urandom_range(0, 2));
            r.height      = wide ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 5) * 1000);
            r.last_record = (i == len - 1);
            offer_record(r, 1'b0);
        end
    endtask

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        res_req_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            n_results++;
            if (results_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: code %0d weight %0d height %0d count %0d last %0b",
                             res.out_code, res.out_weight, res.out_height,
                             res.tie_count, res.last_result);
            end
            else
            begin
                want = results_due.pop_front();
                if (res.out_code !== want.out_code || res.out_weight !== want.out_weight ||
                    res.out_height !== want.out_height || res.tie_count !== want.tie_count ||
                    res.last_result !== want.last_result)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
                                 want.out_code, want.out_weight, want.out_height,
                                 want.tie_count, want.last_result,
                                 res.out_code, res.out_weight, res.out_height,
                                 res.tie_count, res.last_result);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("max_key_ties_sorted_by_second_key test failed");
            $finish;
        end
    end

    initial
    begin
        int set_no;
        int len;
        logic [VAL_W-1:0] w_base;
        rec_req_t full_rec;
        tie_w     = '0;
        tie_n     = 0;
        quiet     = 1'b0;
        hold_go   = 1'b0;
        n_items   = 0;
        n_sets    = 0;
        n_results = 0;
        n_errors  = 0;
        most_ties = 0;
        rst_n     <= 1'b0;
        rec_valid <= 1'b0;
        rec       <= '0;

        // Directed sets: field extremes, ties on equal height, a heavier
        // record clearing the store, zero weight opening a set, and a last
        // record lighter than the maximum.
        dir_rows = '{
            '{rec_of(10'd0,    16'd0,     16'd0,     1'b1), 1'b1},
            '{rec_of(10'd1023, 16'd65535, 16'd65535, 1'b1), 1'b1},
            '{rec_of(10'h2AA,  16'hAAAA,  16'h5555,  1'b1), 1'b1},
            '{rec_of(10'h155,  16'h5555,  16'hAAAA,  1'b1), 1'b1},
            '{rec_of(10'd100,  16'd500,   16'd300,   1'b0), 1'b0},
            '{rec_of(10'd101,  16'd500,   16'd200,   1'b0), 1'b0},
            '{rec_of(10'd102,  16'd500,   16'd300,   1'b0), 1'b0},
            '{rec_of(10'd103,  16'd500,   16'd100,   1'b1), 1'b0},
            '{rec_of(10'd200,  16'd300,   16'd50,    1'b0), 1'b0},
            '{rec_of(10'd201,  16'd700,   16'd900,   1'b0), 1'b0},
            '{rec_of(10'd202,  16'd700,   16'd10,    1'b0), 1'b0},
            '{rec_of(10'd203,  16'd699,   16'd5,     1'b0), 1'b0},
            '{rec_of(10'd204,  16'd700,   16'd900,   1'b1), 1'b0},
            '{rec_of(10'd300,  16'd0,     16'd1,     1'b0), 1'b0},
            '{rec_of(10'd301,  16'd0,     16'd2,     1'b0), 1'b0},
            '{rec_of(10'd302,  16'd1,     16'd65535, 1'b1), 1'b0},
            '{rec_of(10'd400,  16'd1000,  16'd20,    1'b0), 1'b0},
            '{rec_of(10'd401,  16'd999,   16'd10,    1'b1), 1'b0},
            '{rec_of(10'd999,  16'd65535, 16'd0,     1'b0), 1'b0},
            '{rec_of(10'd100,  16'd65535, 16'd0,     1'b0), 1'b0},
            '{rec_of(10'd500,  16'd65535, 16'd65535, 1'b1), 1'b0},
            '{rec_of(10'd1,    16'd1,     16'd1,     1'b1), 1'b1}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            offer_record(dir_rows[i].req, dir_rows[i].solo);

        // Random sets, with one set that overflows the store, one long
        // receiver hold-off, one full drain and one window with no idling.
        set_no = 0;
        while (n_items < N_DIR + RAND_ITEMS)
        begin
            quiet = (set_no >= 12 && set_no < 17);
            w_base = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(65530, 65533))
                                                  : VAL_W'($urandom_range(1, 3000));
            if (set_no == 3)
            begin
                // Every record of this set shares one weight, so the store overflows.
                for (int i = 0; i < FULL_LEN; i++)
                begin
                    full_rec = rec_of(CODE_W'($urandom_range(100, 999)), w_base,
                                      VAL_W'($urandom_range(0, 5) * 1000),
                                      i == FULL_LEN - 1);
                    offer_record(full_rec, 1'b0);
                end
            end
            else
            begin
                if (set_no == 6)
                    hold_go = 1'b1;
                if (set_no == 9)
                begin
                    rec_valid <= 1'b0;
                    @(posedge clk);
                    while (results_due.size() != 0)
                        @(posedge clk);
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 6);
                send_set(len, $urandom_range(0, 4) == 0, w_base);
            end
            set_no++;
        end
        rec_valid <= 1'b0;
        quiet = 1'b0;

        // Let every expected result come out, then watch for strays.
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d records in %0d sets sent, %0d tied results checked",
                 n_items, n_sets, n_results);
        $display("largest tie set %0d, including a store overflow and a long output hold-off",
                 most_ties);
        if (n_errors == 0)
            $display("max_key_ties_sorted_by_second_key test passed");
        else
            $display("max_key_ties_sorted_by_second_key test failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/mkts_pkg.sv
design/mkts_cell.sv
design/max_key_ties_sorted_by_second_key.sv
tb/sv/tb_top.sv
